[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mhls_pkg.sv]
package mhls_pkg;

  localparam int unsigned OPERATION_W = 2;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned CHANNEL_W   = 4;
  localparam int unsigned THRESH_W    = 8;
  localparam int unsigned LINE_W      = 16;
  localparam int unsigned PHASE_W     = 2;

  typedef enum logic [OPERATION_W-1:0] {
    OP_SAMPLE     = 2'd0,
    OP_START_LIT  = 2'd1,
    OP_START_DARK = 2'd2,
    OP_LOAD       = 2'd3
  } op_e;

  typedef enum logic [PHASE_W-1:0] {
    CAL_IDLE = 2'd0,
    CAL_LIT  = 2'd1,
    CAL_DARK = 2'd2
  } cal_mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_REBUILD
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic rebuild_en;
  } dp_cmd_t;

  typedef struct packed {
    logic need_rebuild;
  } dp_status_t;

endpackage

[src/mhls_ctrl.sv]
module mhls_ctrl #(
  parameter int unsigned CHANNELS = 16,
  localparam int unsigned CH_W = $clog2(CHANNELS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mhls_pkg::dp_cmd_t    cmd_o,
  output logic [CH_W-1:0]      rb_idx_o,
  input  mhls_pkg::dp_status_t status_i
);
  import mhls_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [CH_W-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (out_valid_q && out_ready_i) begin
          out_valid_d = 1'b0;
        end
        if (accept) begin
          if (status_i.need_rebuild) begin
            state_d     = ST_REBUILD;
            idx_d       = '0;
            out_valid_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_REBUILD: begin
        if (idx_q == CH_W'(CHANNELS - 1)) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    out_valid_o      = out_valid_q;
    cmd_o.accept     = accept;
    cmd_o.rebuild_en = (state_q == ST_REBUILD);
    rb_idx_o         = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/mhls_datapath.sv]
module mhls_datapath #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned SAMPLE_BITS = 8,
  parameter int unsigned CAL_PASSES  = 4,
  localparam int unsigned CH_W = $clog2(CHANNELS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mhls_pkg::OPERATION_W-1:0]    operation_i,
  input  logic [mhls_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [mhls_pkg::CHANNEL_W-1:0]      target_channel_i,
  input  logic [mhls_pkg::THRESH_W-1:0]       high_value_i,
  input  logic [mhls_pkg::THRESH_W-1:0]       low_value_i,
  input  mhls_pkg::dp_cmd_t                   cmd_i,
  input  logic [CH_W-1:0]                     rb_idx_i,
  output mhls_pkg::dp_status_t                status_o,
  output logic [mhls_pkg::LINE_W-1:0]         line_bits_o,
  output logic [mhls_pkg::CHANNEL_W-1:0]      sampled_channel_o,
  output logic                                frame_end_o,
  output logic [mhls_pkg::PHASE_W-1:0]        calibration_phase_o,
  output logic                                thresholds_updated_o
);
  import mhls_pkg::*;

  localparam int unsigned PASS_W = (CAL_PASSES > 1) ? $clog2(CAL_PASSES) : 1;
  localparam int unsigned SUM_W  = $clog2(CAL_PASSES * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int unsigned RB_W   = SUM_W + 2;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  logic [CHANNELS-1:0]    line_q, line_d;
  logic [SAMPLE_BITS-1:0] high_q [CHANNELS];
  logic [SAMPLE_BITS-1:0] low_q  [CHANNELS];
  logic [SUM_W-1:0]       lit_q  [CHANNELS];
  logic [SUM_W-1:0]       dark_q [CHANNELS];
  logic [CH_W-1:0]        scan_q, scan_d;
  logic [PASS_W-1:0]      pass_q, pass_d;
  cal_mode_e              mode_q, mode_d;

  logic [LINE_W-1:0]      line_bits_q;
  logic [CHANNEL_W-1:0]   sampled_channel_q;
  logic                   frame_end_q;
  cal_mode_e              phase_q;
  logic                   updated_q;

  op_e                    op;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   is_sample;
  logic                   last_ch;
  logic                   last_pass;
  logic                   need_rebuild;
  logic [CH_W-1:0]        rd_idx;
  logic [SUM_W-1:0]       lit_rd, dark_rd;
  logic [RB_W-1:0]        lit_x, dark_x, hi_sum, lo_sum;
  logic [SAMPLE_BITS-1:0] hi_thr, lo_thr;
  logic                   tgt_ok;
  logic [CH_W-1:0]        tgt_idx;

  assign op        = op_e'(operation_i);
  assign smp       = SAMPLE_BITS'(sample_i);
  assign is_sample = (op == OP_SAMPLE);
  assign last_ch   = (scan_q == CH_W'(CHANNELS - 1));
  assign last_pass = (pass_q == PASS_W'(CAL_PASSES - 1));
  assign need_rebuild = is_sample && (mode_q == CAL_DARK) && last_ch && last_pass;
  assign status_o.need_rebuild = need_rebuild;

  assign tgt_ok  = (5'(target_channel_i) < 5'(CHANNELS));
  assign tgt_idx = target_channel_i[CH_W-1:0];

  // One read port on the sums: the rebuild walk or the current scan channel.
  assign rd_idx  = cmd_i.rebuild_en ? rb_idx_i : scan_q;
  assign lit_rd  = lit_q[rd_idx];
  assign dark_rd = dark_q[rd_idx];

  assign lit_x  = RB_W'(lit_rd);
  assign dark_x = RB_W'(dark_rd);
  assign hi_sum = ((lit_x + (lit_x << 1)) >> 4) + (dark_x >> 4);
  assign lo_sum = (lit_x >> 4) + ((dark_x + (dark_x << 1)) >> 4);
  assign hi_thr = (hi_sum > RB_W'(SAMPLE_MAX)) ? SAMPLE_MAX : hi_sum[SAMPLE_BITS-1:0];
  assign lo_thr = (lo_sum > RB_W'(SAMPLE_MAX)) ? SAMPLE_MAX : lo_sum[SAMPLE_BITS-1:0];

  always_comb begin
    line_d = line_q;
    if (is_sample) begin
      if (smp > high_q[scan_q] && !line_q[scan_q]) begin
        line_d[scan_q] = 1'b1;
      end else if (smp < low_q[scan_q] && line_q[scan_q]) begin
        line_d[scan_q] = 1'b0;
      end
    end
  end

  always_comb begin
    scan_d = scan_q;
    pass_d = pass_q;
    mode_d = mode_q;
    case (op)
      OP_SAMPLE: begin
        scan_d = last_ch ? '0 : scan_q + 1'b1;
        if ((mode_q == CAL_LIT || mode_q == CAL_DARK) && last_ch) begin
          if (last_pass) begin
            mode_d = CAL_IDLE;
            pass_d = '0;
          end else begin
            pass_d = pass_q + 1'b1;
          end
        end
      end
      OP_START_LIT: begin
        scan_d = '0;
        pass_d = '0;
        mode_d = CAL_LIT;
      end
      OP_START_DARK: begin
        scan_d = '0;
        pass_d = '0;
        mode_d = CAL_DARK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      scan_q <= '0;
      pass_q <= '0;
      mode_q <= CAL_IDLE;
    end else if (cmd_i.accept) begin
      line_q <= line_d;
      scan_q <= scan_d;
      pass_q <= pass_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < CHANNELS; n++) begin
        lit_q[n]  <= '0;
        dark_q[n] <= '0;
      end
    end else if (cmd_i.accept) begin
      if (op == OP_START_LIT) begin
        for (int n = 0; n < CHANNELS; n++) begin
          lit_q[n] <= '0;
        end
      end else if (op == OP_START_DARK) begin
        for (int n = 0; n < CHANNELS; n++) begin
          dark_q[n] <= '0;
        end
      end else if (is_sample && mode_q == CAL_LIT) begin
        lit_q[scan_q] <= lit_rd + SUM_W'(smp);
      end else if (is_sample && mode_q == CAL_DARK) begin
        dark_q[scan_q] <= dark_rd + SUM_W'(smp);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < CHANNELS; n++) begin
        high_q[n] <= SAMPLE_MAX;
        low_q[n]  <= '0;
      end
    end else if (cmd_i.rebuild_en) begin
      high_q[rb_idx_i] <= hi_thr;
      low_q[rb_idx_i]  <= lo_thr;
    end else if (cmd_i.accept && op == OP_LOAD && tgt_ok) begin
      high_q[tgt_idx] <= SAMPLE_BITS'(high_value_i);
      low_q[tgt_idx]  <= SAMPLE_BITS'(low_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      line_bits_q       <= LINE_W'(line_d);
      sampled_channel_q <= is_sample ? CHANNEL_W'(scan_q) : '0;
      frame_end_q       <= is_sample && last_ch;
      phase_q           <= mode_d;
      updated_q         <= need_rebuild;
    end
  end

  assign line_bits_o          = line_bits_q;
  assign sampled_channel_o    = sampled_channel_q;
  assign frame_end_o          = frame_end_q;
  assign calibration_phase_o  = phase_q;
  assign thresholds_updated_o = updated_q;

endmodule

[src/multichannel_hysteresis_line_sensor_core.sv]
// Multichannel hysteresis line sensor core.
// Input channel (in_valid_i/in_ready_o): one operation per transfer - a sample
// for the next channel of the internal scan rotation, a start of lit or dark
// calibration, or a load of one channel's threshold pair.
// Output channel (out_valid_o/out_ready_i): exactly one result per input
// transfer, in order: line bitmap, sampled channel, frame end, phase, and the
// thresholds-rebuilt flag.
// Result: registered, valid in the cycle after the input transfer. The sample
// that ends the last dark pass rebuilds every threshold pair, one channel per
// cycle, and its result shows once the walk has passed the last channel.
// Throughput: one item per cycle while results are taken; a rebuild holds the
// input off until it has walked every channel.
// Stall: a single output register holds the result; outside a rebuild,
// in_ready_o is high while it is empty or taken in the same cycle; else low.
// Reset: hysteresis bits, sums, scan channel and pass count clear, high
// thresholds go to full scale, low thresholds to zero, calibration goes idle.
module multichannel_hysteresis_line_sensor_core #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned SAMPLE_BITS = 8,
  parameter int unsigned CAL_PASSES  = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mhls_pkg::OPERATION_W-1:0] operation_i,
  input  logic [mhls_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [mhls_pkg::CHANNEL_W-1:0]   target_channel_i,
  input  logic [mhls_pkg::THRESH_W-1:0]    high_value_i,
  input  logic [mhls_pkg::THRESH_W-1:0]    low_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mhls_pkg::LINE_W-1:0]      line_bits_o,
  output logic [mhls_pkg::CHANNEL_W-1:0]   sampled_channel_o,
  output logic                             frame_end_o,
  output logic [mhls_pkg::PHASE_W-1:0]     calibration_phase_o,
  output logic                             thresholds_updated_o
);
  import mhls_pkg::*;

  localparam int unsigned CH_W = $clog2(CHANNELS);

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [CH_W-1:0] rb_idx;

  mhls_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .rb_idx_o    (rb_idx),
    .status_i    (status)
  );

  mhls_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CAL_PASSES  (CAL_PASSES)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .operation_i          (operation_i),
    .sample_i             (sample_i),
    .target_channel_i     (target_channel_i),
    .high_value_i         (high_value_i),
    .low_value_i          (low_value_i),
    .cmd_i                (cmd),
    .rb_idx_i             (rb_idx),
    .status_o             (status),
    .line_bits_o          (line_bits_o),
    .sampled_channel_o    (sampled_channel_o),
    .frame_end_o          (frame_end_o),
    .calibration_phase_o  (calibration_phase_o),
    .thresholds_updated_o (thresholds_updated_o)
  );

endmodule

[src/mhls_checker.sv]
`include "assert_macros.svh"

module mhls_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [mhls_pkg::OPERATION_W-1:0] operation_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [mhls_pkg::LINE_W-1:0]      line_bits_o,
  input logic [mhls_pkg::CHANNEL_W-1:0]   sampled_channel_o,
  input logic                             frame_end_o,
  input logic [mhls_pkg::PHASE_W-1:0]     calibration_phase_o,
  input logic                             thresholds_updated_o
);
  import mhls_pkg::*;

  logic in_xfer;
  logic out_stall;
  logic cmd_xfer;
  logic cmd_fields_ok;
  logic frame_end_seen;
  logic last_channel;
  logic rebuild_seen;
  logic rebuild_ok;

  assign in_xfer        = in_valid_i && in_ready_o;
  assign out_stall      = out_valid_o && !out_ready_i;
  assign cmd_xfer       = in_xfer && (operation_i != OP_SAMPLE);
  assign cmd_fields_ok  = out_valid_o && (sampled_channel_o == '0) && !frame_end_o &&
                          !thresholds_updated_o;
  assign frame_end_seen = out_valid_o && frame_end_o;
  assign last_channel   = (sampled_channel_o == CHANNEL_W'(CHANNELS - 1));
  assign rebuild_seen   = out_valid_o && thresholds_updated_o;
  assign rebuild_ok     = frame_end_o && (calibration_phase_o == CAL_IDLE);

  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(line_bits_o), "result moved")
  `CHK_NEXT(a_cmd_result, clk_i, rst_ni, cmd_xfer, cmd_fields_ok, "command result wrong")
  `CHK_IMPLIES(a_frame_end, clk_i, rst_ni, frame_end_seen, last_channel, "frame end misplaced")
  `CHK_IMPLIES(a_rebuild_idle, clk_i, rst_ni, rebuild_seen, rebuild_ok, "rebuild flag misplaced")

endmodule

bind multichannel_hysteresis_line_sensor_core mhls_checker #(
  .CHANNELS (CHANNELS)
) u_mhls_checker (.*);
